// ----- sv/owef_pkg.sv -----
package owef_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int QCOUNT_W    = 5;
   localparam int DROP_W      = 16;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_PEEK  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] code_in;
      logic [7:0]  severity_in;
      logic [31:0] data_in;
      logic [31:0] time_in;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [31:0]         time_out;
      logic [15:0]         code_out;
      logic [7:0]          severity_out;
      logic [31:0]         data_out;
      logic                overwrote;
      logic [QCOUNT_W-1:0] queue_count;
      logic [DROP_W-1:0]   dropped_total;
   } rsp_type;

   typedef struct packed {
      logic [31:0] stamp;
      logic [15:0] code;
      logic [7:0]  sev;
      logic [31:0] data;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } ram_cmd_type;

   typedef struct packed {
      logic                found;
      logic                overwrote;
      logic [QCOUNT_W-1:0] queue_count;
      logic [DROP_W-1:0]   dropped_total;
   } status_type;

endpackage

// ----- sv/owef_ram.sv -----
module owef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/owef_ctrl.sv -----
module owef_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            func,
   output owef_pkg::ram_cmd_type ram_cmd,
   output owef_pkg::status_type  status
);

   localparam logic [owef_pkg::PTR_W-1:0] LAST_PTR =
      owef_pkg::PTR_W'(owef_pkg::QUEUE_DEPTH - 1);
   localparam logic [owef_pkg::CNT_W-1:0] FULL_CNT =
      owef_pkg::CNT_W'(owef_pkg::QUEUE_DEPTH);

   logic [owef_pkg::PTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [owef_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [owef_pkg::DROP_W-1:0] drop_ff, drop_in;
   logic                        full, empty;
   logic [owef_pkg::PTR_W-1:0]  wp_next, rp_next;

   assign full    = (cnt_ff == FULL_CNT);
   assign empty   = (cnt_ff == '0);
   assign wp_next = (wp_ff == LAST_PTR) ? '0 : wp_ff + 1'b1;
   assign rp_next = (rp_ff == LAST_PTR) ? '0 : rp_ff + 1'b1;

   always_comb begin
      wp_in            = wp_ff;
      rp_in            = rp_ff;
      cnt_in           = cnt_ff;
      drop_in          = drop_ff;
      ram_cmd.wr_en    = 1'b0;
      ram_cmd.wr_addr  = wp_ff;
      ram_cmd.rd_en    = 1'b0;
      ram_cmd.rd_addr  = rp_ff;
      status.found     = 1'b0;
      status.overwrote = 1'b0;
      if (accept) begin
         unique case (func)
            owef_pkg::OP_PUSH: begin
               ram_cmd.wr_en = 1'b1;
               wp_in         = wp_next;
               if (full) begin
                  // drop the oldest entry, count stays at full
                  rp_in            = rp_next;
                  drop_in          = drop_ff + 1'b1;
                  status.overwrote = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            owef_pkg::OP_POP: begin
               if (!empty) begin
                  ram_cmd.rd_en = 1'b1;
                  status.found  = 1'b1;
                  rp_in         = rp_next;
                  cnt_in        = cnt_ff - 1'b1;
               end
            end
            owef_pkg::OP_PEEK: begin
               if (!empty) begin
                  ram_cmd.rd_en = 1'b1;
                  status.found  = 1'b1;
               end
            end
            owef_pkg::OP_CLEAR: begin
               wp_in  = '0;
               rp_in  = '0;
               cnt_in = '0;
            end
            default: begin
               wp_in = wp_ff;
            end
         endcase
      end
      status.queue_count   = owef_pkg::QCOUNT_W'(cnt_in);
      status.dropped_total = drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         cnt_ff  <= '0;
         drop_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         cnt_ff  <= cnt_in;
         drop_ff <= drop_in;
      end
   end

endmodule

// ----- sv/overwrite_oldest_event_fifo_top.sv -----
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   owef_pkg::req_type req_data
// rsp      out        rsp_valid/rsp_ready   owef_pkg::rsp_type rsp_data
//
// One transaction per cycle sustained while rsp_ready stays high; each result
// passes through the entry-memory read register and then the output register.
// Pointers, count and dropped counter update at accept, so back-to-back
// operations see each other without forwarding. Synchronous reset empties the
// queue and clears the dropped counter; entry memory is not cleared.
// A stalled rsp channel backs up through the read stage into req_ready.
module overwrite_oldest_event_fifo_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  owef_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output owef_pkg::rsp_type rsp_data
);

   owef_pkg::ram_cmd_type     ram_cmd;
   owef_pkg::status_type      status;
   owef_pkg::status_type      s1_status_ff;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   owef_pkg::rsp_type         rsp_data_ff;
   owef_pkg::entry_type       wr_entry, rd_entry;
   logic [owef_pkg::ENTRY_W-1:0] rd_raw;
   logic                      accept, rsp_free, s1_move;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || rsp_free;
   assign accept    = req_valid && req_ready;

   owef_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .func    (req_data.func),
      .ram_cmd (ram_cmd),
      .status  (status)
   );

   assign wr_entry.stamp = req_data.time_in;
   assign wr_entry.code  = req_data.code_in;
   assign wr_entry.sev   = req_data.severity_in;
   assign wr_entry.data  = req_data.data_in;

   owef_ram #(
      .WIDTH (owef_pkg::ENTRY_W),
      .DEPTH (owef_pkg::QUEUE_DEPTH),
      .AW    (owef_pkg::PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (wr_entry),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = owef_pkg::entry_type'(rd_raw);

   assign s1_valid_in  = accept || (s1_valid_ff && !rsp_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the status beside the pending memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff.found         <= s1_status_ff.found;
         rsp_data_ff.time_out      <= s1_status_ff.found ? rd_entry.stamp : '0;
         rsp_data_ff.code_out      <= s1_status_ff.found ? rd_entry.code  : '0;
         rsp_data_ff.severity_out  <= s1_status_ff.found ? rd_entry.sev   : '0;
         rsp_data_ff.data_out      <= s1_status_ff.found ? rd_entry.data  : '0;
         rsp_data_ff.overwrote     <= s1_status_ff.overwrote;
         rsp_data_ff.queue_count   <= s1_status_ff.queue_count;
         rsp_data_ff.dropped_total <= s1_status_ff.dropped_total;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int FLOOD_PUSHES = owef_pkg::QUEUE_DEPTH + 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   owef_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   owef_pkg::rsp_type rsp_data;

   overwrite_oldest_event_fifo_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // event ring as the block should hold it
   owef_pkg::entry_type        ring [owef_pkg::QUEUE_DEPTH];
   logic [owef_pkg::PTR_W-1:0] head_idx = '0;
   logic [owef_pkg::PTR_W-1:0] tail_idx = '0;
   int                         held = 0;
   logic [15:0]                drops = '0;

   owef_pkg::req_type pending_ops [$];
   owef_pkg::rsp_type expected_rsp [$];
   int                fail_count = 0;
   int unsigned       cycle_count = 0;
   int unsigned       send_gap = 0;
   int unsigned       recv_stall = 0;
   logic              calm = 1'b0;
   logic              quiet = 1'b0;

   function automatic logic [owef_pkg::PTR_W-1:0] next_idx(logic [owef_pkg::PTR_W-1:0] p);
      return (p == owef_pkg::PTR_W'(owef_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic owef_pkg::rsp_type apply_event_op(owef_pkg::req_type r);
      owef_pkg::rsp_type res;
      res = '0;
      case (r.func)
         owef_pkg::OP_PUSH: begin
            if (held == owef_pkg::QUEUE_DEPTH) begin
               drops = drops + 1'b1;
               head_idx = next_idx(head_idx);
               held = held - 1;
               res.overwrote = 1'b1;
            end
            ring[tail_idx] = '{stamp: r.time_in, code: r.code_in, sev: r.severity_in,
                               data: r.data_in};
            tail_idx = next_idx(tail_idx);
            held = held + 1;
         end
         owef_pkg::OP_POP, owef_pkg::OP_PEEK: begin
            if (held != 0) begin
               res.found = 1'b1;
               res.time_out = ring[head_idx].stamp;
               res.code_out = ring[head_idx].code;
               res.severity_out = ring[head_idx].sev;
               res.data_out = ring[head_idx].data;
               if (r.func == owef_pkg::OP_POP) begin
                  head_idx = next_idx(head_idx);
                  held = held - 1;
               end
            end
         end
         owef_pkg::OP_CLEAR: begin
            head_idx = '0;
            tail_idx = '0;
            held = 0;
         end
      endcase
      res.queue_count = held[owef_pkg::QCOUNT_W-1:0];
      res.dropped_total = drops;
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   function automatic owef_pkg::req_type rand_req(logic [1:0] op);
      owef_pkg::req_type r;
      r.func = op;
      r.code_in = 16'($urandom);
      r.severity_in = 8'($urandom);
      r.data_in = $urandom;
      r.time_in = $urandom;
      return r;
   endfunction

   function automatic owef_pkg::req_type flat_req(logic [1:0] op, logic fill);
      owef_pkg::req_type r;
      r = fill ? '1 : '0;
      r.func = op;
      return r;
   endfunction

   // driver: present one transaction at a time, predict on accept
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
         calm <= 1'b0;
         quiet <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_rsp.push_back(apply_event_op(req_data));
         calm <= pending_ops.size() < 150;
         if ($urandom_range(0, 59) == 0)
            quiet <= $urandom_range(0, 2) == 0;
         if (req_valid && !req_ready) begin
            // hold the transaction until accepted
         end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            req_data <= pending_ops.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      owef_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result transaction: 0x%0h", rsp_data);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("found", 32'(want.found), 32'(rsp_data.found));
               check_field("time_out", want.time_out, rsp_data.time_out);
               check_field("code_out", 32'(want.code_out), 32'(rsp_data.code_out));
               check_field("severity_out", 32'(want.severity_out),
                           32'(rsp_data.severity_out));
               check_field("data_out", want.data_out, rsp_data.data_out);
               check_field("overwrote", 32'(want.overwrote), 32'(rsp_data.overwrote));
               check_field("queue_count", 32'(want.queue_count),
                           32'(rsp_data.queue_count));
               check_field("dropped_total", 32'(want.dropped_total),
                           32'(rsp_data.dropped_total));
            end
         end
         if (recv_stall != 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
            recv_stall <= $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[overwrite_oldest_event_fifo_top] ERROR");
         $finish;
      end
   end

   // random traffic in runs that lean toward filling or draining the ring, or mix both
   task automatic add_random_ops(int count);
      int          run_left;
      int unsigned mode;
      int unsigned roll;
      logic [1:0]  op;
      run_left = 0;
      mode = 0;
      repeat (count) begin
         if (run_left == 0) begin
            run_left = $urandom_range(8, 40);
            mode = $urandom_range(0, 2);
         end
         run_left--;
         roll = $urandom_range(0, 99);
         if (roll < 2)
            op = owef_pkg::OP_CLEAR;
         else if (mode == 0)
            op = (roll < 75) ? owef_pkg::OP_PUSH :
                 (roll < 90) ? owef_pkg::OP_POP : owef_pkg::OP_PEEK;
         else if (mode == 1)
            op = (roll < 25) ? owef_pkg::OP_PUSH :
                 (roll < 85) ? owef_pkg::OP_POP : owef_pkg::OP_PEEK;
         else
            op = (roll < 45) ? owef_pkg::OP_PUSH :
                 (roll < 80) ? owef_pkg::OP_POP : owef_pkg::OP_PEEK;
         pending_ops.push_back(rand_req(op));
      end
   endtask

   initial begin
      // empty queue, field extremes, overflow, clear
      pending_ops.push_back(flat_req(owef_pkg::OP_POP, 1'b1));
      pending_ops.push_back(flat_req(owef_pkg::OP_PEEK, 1'b0));
      pending_ops.push_back(flat_req(owef_pkg::OP_PUSH, 1'b0));
      pending_ops.push_back(flat_req(owef_pkg::OP_PUSH, 1'b1));
      pending_ops.push_back(flat_req(owef_pkg::OP_PEEK, 1'b0));
      pending_ops.push_back(flat_req(owef_pkg::OP_POP, 1'b0));
      pending_ops.push_back(flat_req(owef_pkg::OP_POP, 1'b1));
      for (int i = 0; i <= owef_pkg::QUEUE_DEPTH; i++)
         pending_ops.push_back(flat_req(owef_pkg::OP_PUSH, i[0]));
      pending_ops.push_back(flat_req(owef_pkg::OP_PEEK, 1'b1));
      pending_ops.push_back(flat_req(owef_pkg::OP_CLEAR, 1'b1));
      pending_ops.push_back(flat_req(owef_pkg::OP_POP, 1'b0));

      add_random_ops(560);
      // overflow well past a full ring
      repeat (FLOOD_PUSHES)
         pending_ops.push_back(rand_req(owef_pkg::OP_PUSH));
      add_random_ops(600);

      while (reset)
         @(posedge clock);
      while (pending_ops.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (10)
         @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0)
         $display("[overwrite_oldest_event_fifo_top] OK");
      else
         $display("[overwrite_oldest_event_fifo_top] ERROR");
      $finish;
   end

   initial begin
      repeat (11)
         @(posedge clock);
      reset <= 1'b0;
   end

endmodule
